/* hdl/ffha_pkg.sv */
// Package for the first-fit heap allocator: sizes, codes, controller states
// and the command/status structs between controller and datapath. No dependencies.
package ffha_pkg;

    localparam int HEAP_BYTES_DEF  = 16384;
    localparam int HEADER_BYTES    = 16;
    localparam int MIN_SPLIT_BYTES = 20;
    localparam int ALIGN_BYTES     = 4;
    localparam int BASE_W          = 32;
    localparam int LIMIT_W         = 15;
    localparam int REQ_W           = 15;
    localparam int CFG_IDX_W       = 1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16384);

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FAIL   = 2'd1,
        ST_BAD    = 2'd2,
        ST_DOUBLE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_CHK, S_A_EVAL, S_A_TAKE, S_A_GROW,
        S_F_CHK, S_F_EVAL, S_C_CHK, S_C_EVAL1, S_C_EVAL2, S_C_KILL, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE, WR_CLEAR, WR_REM, WR_TAKE, WR_GROW, WR_MARK, WR_MERGE, WR_KILL
    } t_wr_kind;

    typedef enum logic [1:0] {
        RD_OFF, RD_REL, RD_NX
    } t_rd_sel;

    typedef enum logic [1:0] {
        RA_ZERO, RA_OFF, RA_BRK
    } t_res_addr;

    typedef struct packed {
        logic      cap;        // capture input word, zero walk offset
        logic      clr_inc;
        logic      rd_en;
        t_rd_sel   rd_sel;
        t_wr_kind  wr_kind;
        logic      off_zero;
        logic      off_nx;
        logic      nx_from_ent; // advance from latched entry, not read data
        logic      ent_ld;
        logic      t_ld;
        logic      brk_ld;
        logic      res_ld;
        t_status   res_st;
        t_res_addr res_addr;
        logic      out_ld;
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_last;
        logic cmd_free;
        logic need_zero;
        logic off_lt_brk;
        logic fit;
        logic split;
        logic grow_fail;
        logic rel_null;
        logic rel_bad;
        logic ent_start;
        logic ent_free;
        logic merge_ok;
        logic out_free;
    } t_dp_stat;

endpackage

/* hdl/first_fit_heap_allocator_core.sv */
// Top level of the first-fit heap allocator.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp.
//
// First-fit allocator over a heap of HEAP_BYTES bytes at heap_base, with a
// 16-byte header per block, 4-byte rounding, block splitting and merging of
// free neighbors. After reset the block walks the header memory once to clear
// it, while o_in_stall stays high; configuration writes are taken throughout.
// One word is handled at a time. An allocate visits the blocks in address
// order through the single-port header memory until one fits, else it grows
// the heap at the break; a valid free marks its block and then runs a merge
// pass that joins each free block with a free block that follows it. The
// result is held in an output register, so the next word is taken while it
// waits.
module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ffha_pkg::BASE_W-1:0]      i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic [ffha_pkg::REQ_W-1:0]       i_request_bytes,
    input  logic [ffha_pkg::BASE_W-1:0]      i_release_address,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ffha_pkg::BASE_W-1:0]      o_payload_address,
    output logic [1:0]                       o_status
);

    ffha_pkg::t_ctl_cmd ctl_cmd;
    ffha_pkg::t_dp_stat dp_stat;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (ctl_cmd)
    );

    ffha_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (ctl_cmd),
        .o_stat            (dp_stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cmd_bit         (i_cmd),
        .i_request_bytes   (i_request_bytes),
        .i_release_address (i_release_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_payload_address (o_payload_address),
        .o_status          (o_status)
    );

endmodule

/* hdl/ffha_ctrl.sv */
// Controller state machine of the heap allocator.
// Depends on ffha_pkg; drives command word to ffha_dp, reads its status.
module ffha_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ffha_pkg::t_dp_stat  i_stat,
    output ffha_pkg::t_ctl_cmd  o_cmd
);

    ffha_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ffha_pkg::S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffha_pkg::S_CLEAR: begin
                if (i_stat.clr_last) n_state = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.cmd_free ? ffha_pkg::S_F_CHK : ffha_pkg::S_A_CHK;
                end
            end
            ffha_pkg::S_A_CHK: begin
                if (i_stat.need_zero)       n_state = ffha_pkg::S_DONE;
                else if (i_stat.off_lt_brk) n_state = ffha_pkg::S_A_EVAL;
                else                        n_state = ffha_pkg::S_A_GROW;
            end
            ffha_pkg::S_A_EVAL: begin
                n_state = i_stat.fit ? ffha_pkg::S_A_TAKE : ffha_pkg::S_A_CHK;
            end
            ffha_pkg::S_A_TAKE: n_state = ffha_pkg::S_DONE;
            ffha_pkg::S_A_GROW: n_state = ffha_pkg::S_DONE;
            ffha_pkg::S_F_CHK: begin
                if (i_stat.rel_null || i_stat.rel_bad) n_state = ffha_pkg::S_DONE;
                else                                    n_state = ffha_pkg::S_F_EVAL;
            end
            ffha_pkg::S_F_EVAL: begin
                if (!i_stat.ent_start || i_stat.ent_free) n_state = ffha_pkg::S_DONE;
                else                                       n_state = ffha_pkg::S_C_CHK;
            end
            ffha_pkg::S_C_CHK: begin
                n_state = i_stat.off_lt_brk ? ffha_pkg::S_C_EVAL1 : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_C_EVAL1: begin
                n_state = i_stat.merge_ok ? ffha_pkg::S_C_EVAL2 : ffha_pkg::S_C_CHK;
            end
            ffha_pkg::S_C_EVAL2: begin
                n_state = i_stat.ent_free ? ffha_pkg::S_C_KILL : ffha_pkg::S_C_CHK;
            end
            ffha_pkg::S_C_KILL: n_state = ffha_pkg::S_C_CHK;
            ffha_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = ffha_pkg::S_IDLE;
            end
            default: n_state = ffha_pkg::S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_sel   = ffha_pkg::RD_OFF;
        o_cmd.wr_kind  = ffha_pkg::WR_NONE;
        o_cmd.res_st   = ffha_pkg::ST_OK;
        o_cmd.res_addr = ffha_pkg::RA_ZERO;
        case (r_state)
            ffha_pkg::S_CLEAR: begin
                o_cmd.wr_kind = ffha_pkg::WR_CLEAR;
                o_cmd.clr_inc = 1'b1;
            end
            ffha_pkg::S_IDLE: begin
                o_cmd.cap = i_in_valid;
            end
            ffha_pkg::S_A_CHK: begin
                if (i_stat.need_zero) begin
                    o_cmd.res_ld = 1'b1;
                    o_cmd.res_st = ffha_pkg::ST_FAIL;
                end else if (i_stat.off_lt_brk) begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            ffha_pkg::S_A_EVAL: begin
                o_cmd.ent_ld = 1'b1;
                if (i_stat.fit) begin
                    if (i_stat.split) o_cmd.wr_kind = ffha_pkg::WR_REM;
                end else begin
                    o_cmd.off_nx = 1'b1;
                end
            end
            ffha_pkg::S_A_TAKE: begin
                o_cmd.wr_kind  = ffha_pkg::WR_TAKE;
                o_cmd.res_ld   = 1'b1;
                o_cmd.res_addr = ffha_pkg::RA_OFF;
            end
            ffha_pkg::S_A_GROW: begin
                o_cmd.res_ld = 1'b1;
                if (i_stat.grow_fail) begin
                    o_cmd.res_st = ffha_pkg::ST_FAIL;
                end else begin
                    o_cmd.wr_kind  = ffha_pkg::WR_GROW;
                    o_cmd.brk_ld   = 1'b1;
                    o_cmd.res_addr = ffha_pkg::RA_BRK;
                end
            end
            ffha_pkg::S_F_CHK: begin
                if (i_stat.rel_null) begin
                    o_cmd.res_ld = 1'b1;
                end else if (i_stat.rel_bad) begin
                    o_cmd.res_ld = 1'b1;
                    o_cmd.res_st = ffha_pkg::ST_BAD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ffha_pkg::RD_REL;
                end
            end
            ffha_pkg::S_F_EVAL: begin
                o_cmd.res_ld = 1'b1;
                if (!i_stat.ent_start) begin
                    o_cmd.res_st = ffha_pkg::ST_BAD;
                end else if (i_stat.ent_free) begin
                    o_cmd.res_st = ffha_pkg::ST_DOUBLE;
                end else begin
                    o_cmd.wr_kind  = ffha_pkg::WR_MARK;
                    o_cmd.off_zero = 1'b1;
                end
            end
            ffha_pkg::S_C_CHK: begin
                o_cmd.rd_en = i_stat.off_lt_brk;
            end
            ffha_pkg::S_C_EVAL1: begin
                o_cmd.ent_ld = 1'b1;
                if (i_stat.merge_ok) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ffha_pkg::RD_NX;
                end else begin
                    o_cmd.off_nx = 1'b1;
                end
            end
            ffha_pkg::S_C_EVAL2: begin
                if (i_stat.ent_free) begin
                    o_cmd.wr_kind = ffha_pkg::WR_MERGE;
                    o_cmd.t_ld    = 1'b1;
                end else begin
                    o_cmd.off_nx      = 1'b1;
                    o_cmd.nx_from_ent = 1'b1;
                end
            end
            ffha_pkg::S_C_KILL: begin
                o_cmd.wr_kind = ffha_pkg::WR_KILL;
            end
            ffha_pkg::S_DONE: begin
                o_cmd.out_ld = i_stat.out_free;
            end
            default: ;
        endcase
    end

    // a capture happens only from idle, and idle is the only unstalled state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cap |-> !o_in_stall)
        else $error("capture outside idle");
    // the memory never sees a read and a write in the same cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (o_cmd.wr_kind == ffha_pkg::WR_NONE))
        else $error("read and write collide");
    // a result is produced on the way to completion or to the merge pass
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_ld |=> (r_state == ffha_pkg::S_DONE || r_state == ffha_pkg::S_C_CHK))
        else $error("result loaded outside completion");

endmodule

/* hdl/ffha_dp.sv */
// Datapath of the heap allocator: header memory, walk offset, break,
// configuration and output registers. Depends on ffha_pkg; driven by ffha_ctrl.
module ffha_dp #(
    parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ffha_pkg::t_ctl_cmd                   i_cmd,
    output ffha_pkg::t_dp_stat                   o_stat,
    input  logic                                 i_cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ffha_pkg::BASE_W-1:0]          i_cfg_data,
    input  logic                                 i_cmd_bit,
    input  logic [ffha_pkg::REQ_W-1:0]           i_request_bytes,
    input  logic [ffha_pkg::BASE_W-1:0]          i_release_address,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [ffha_pkg::BASE_W-1:0]          o_payload_address,
    output logic [1:0]                           o_status
);

    localparam int SLOTS = HEAP_BYTES / ffha_pkg::ALIGN_BYTES;
    localparam int SW    = $clog2(SLOTS);
    localparam int OW    = $clog2(HEAP_BYTES + 1);
    localparam int AW    = ((OW > ffha_pkg::REQ_W + 1) ? OW : ffha_pkg::REQ_W + 1) + 2;
    localparam int EW    = OW + 2;
    localparam int BW    = ffha_pkg::BASE_W;

    localparam logic [AW-1:0] HDR_A   = AW'(ffha_pkg::HEADER_BYTES);
    localparam logic [AW-1:0] SPLIT_A = AW'(ffha_pkg::MIN_SPLIT_BYTES);
    localparam logic [AW-1:0] HEAP_A  = AW'(HEAP_BYTES);
    localparam logic [BW-1:0] HDR_B   = BW'(ffha_pkg::HEADER_BYTES);

    // entry layout: {start, free, size}
    logic [EW-1:0]   r_mem [SLOTS];
    logic [EW-1:0]   r_rdata;
    logic [SW-1:0]   r_clr;
    logic [AW-1:0]   r_need;
    logic [BW-1:0]   r_rel;
    logic [OW-1:0]   r_off, r_brk;
    logic [EW-1:0]   r_ent;
    logic [SW-1:0]   r_t;
    logic [BW-1:0]   r_base;
    logic [ffha_pkg::LIMIT_W-1:0] r_limit;
    logic [BW-1:0]   r_res_addr, r_out_addr;
    ffha_pkg::t_status r_res_st, r_out_st;
    logic            r_out_valid;

    logic [AW-1:0]   rd_size, ent_size, off_a, brk_a, nx_rd, nx_ent, grow_end, lim_a;
    logic [AW-1:0]   req_a, need_in, rem_a;
    logic [BW-1:0]   rel_off, rel_h;
    logic [SW-1:0]   raddr, waddr;
    logic [EW-1:0]   wdata;
    logic            we;

    assign rd_size  = AW'(r_rdata[OW-1:0]);
    assign ent_size = AW'(r_ent[OW-1:0]);
    assign off_a    = AW'(r_off);
    assign brk_a    = AW'(r_brk);
    assign nx_rd    = off_a + HDR_A + rd_size;
    assign nx_ent   = off_a + HDR_A + ent_size;
    assign rem_a    = off_a + HDR_A + r_need;
    assign grow_end = brk_a + HDR_A + r_need;
    assign lim_a    = (AW'(r_limit) < HEAP_A) ? AW'(r_limit) : HEAP_A;
    assign req_a    = AW'(i_request_bytes) + AW'(3);
    assign need_in  = {req_a[AW-1:2], 2'b00};
    assign rel_off  = r_rel - r_base;
    assign rel_h    = rel_off - HDR_B;

    always_comb begin
        o_stat            = '0;
        o_stat.clr_last   = (r_clr == SW'(SLOTS - 1));
        o_stat.cmd_free   = (i_cmd_bit == ffha_pkg::CMD_FREE);
        o_stat.need_zero  = (r_need == '0);
        o_stat.off_lt_brk = (r_off < r_brk);
        o_stat.fit        = r_rdata[EW-2] && (rd_size >= r_need);
        o_stat.split      = (rd_size - r_need) >= SPLIT_A;
        o_stat.grow_fail  = grow_end > lim_a;
        o_stat.rel_null   = (r_rel == '0);
        o_stat.rel_bad    = (rel_off < HDR_B) || (rel_h >= BW'(r_brk))
                            || (rel_off[1:0] != 2'b00);
        o_stat.ent_start  = r_rdata[EW-1];
        o_stat.ent_free   = r_rdata[EW-2];
        o_stat.merge_ok   = r_rdata[EW-2] && (nx_rd < brk_a);
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    // memory addressing
    always_comb begin
        case (i_cmd.rd_sel)
            ffha_pkg::RD_OFF: raddr = r_off[SW+1:2];
            ffha_pkg::RD_REL: raddr = rel_h[SW+1:2];
            ffha_pkg::RD_NX:  raddr = nx_rd[SW+1:2];
            default:          raddr = r_off[SW+1:2];
        endcase
        we    = 1'b1;
        waddr = r_off[SW+1:2];
        wdata = '0;
        case (i_cmd.wr_kind)
            ffha_pkg::WR_CLEAR: waddr = r_clr;
            ffha_pkg::WR_REM: begin
                waddr = rem_a[SW+1:2];
                wdata = {2'b11, OW'(rd_size - r_need - HDR_A)};
            end
            ffha_pkg::WR_TAKE: begin
                wdata = {2'b10, (ent_size - r_need >= SPLIT_A) ? OW'(r_need) : OW'(ent_size)};
            end
            ffha_pkg::WR_GROW: begin
                waddr = r_brk[SW+1:2];
                wdata = {2'b10, OW'(r_need)};
            end
            ffha_pkg::WR_MARK: begin
                waddr = rel_h[SW+1:2];
                wdata = {2'b11, r_rdata[OW-1:0]};
            end
            ffha_pkg::WR_MERGE: begin
                wdata = {2'b11, OW'(ent_size + rd_size + HDR_A)};
            end
            ffha_pkg::WR_KILL: waddr = r_t;
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (i_cmd.rd_en) r_rdata <= r_mem[raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_brk       <= '0;
            r_off       <= '0;
            r_base      <= '0;
            r_limit     <= ffha_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_inc) r_clr <= r_clr + SW'(1);
            if (i_cmd.brk_ld)  r_brk <= OW'(grow_end);
            if (i_cmd.cap || i_cmd.off_zero) begin
                r_off <= '0;
            end else if (i_cmd.off_nx) begin
                r_off <= i_cmd.nx_from_ent ? OW'(nx_ent) : OW'(nx_rd);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ffha_pkg::CFG_HEAP_BASE:  r_base  <= i_cfg_data;
                    ffha_pkg::CFG_HEAP_LIMIT: r_limit <= i_cfg_data[ffha_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.out_ld)             r_out_valid <= 1'b1;
            else if (!i_out_stall)        r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_need <= need_in;
            r_rel  <= i_release_address;
        end
        if (i_cmd.ent_ld) r_ent <= r_rdata;
        if (i_cmd.t_ld)   r_t   <= nx_ent[SW+1:2];
        if (i_cmd.res_ld) begin
            r_res_st <= i_cmd.res_st;
            case (i_cmd.res_addr)
                ffha_pkg::RA_OFF: r_res_addr <= r_base + BW'(r_off) + HDR_B;
                ffha_pkg::RA_BRK: r_res_addr <= r_base + BW'(r_brk) + HDR_B;
                default:          r_res_addr <= '0;
            endcase
        end
        if (i_cmd.out_ld) begin
            r_out_addr <= r_res_addr;
            r_out_st   <= r_res_st;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_payload_address = r_out_addr;
    assign o_status          = r_out_st;

    // the break only grows
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.brk_ld |=> (r_brk >= $past(r_brk)))
        else $error("break moved down");
    // the break stays word aligned
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_brk[1:0] == 2'b00)
        else $error("break misaligned");
    // a failed result never carries an address
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_out_st != ffha_pkg::ST_OK))
        |-> (o_payload_address == '0))
        else $error("address on non-grant");

endmodule

/* test/tb.sv */
// Self-checking testbench for first_fit_heap_allocator_core.
// Depends on ffha_pkg and the allocator RTL; predicts each result word from a
// behavioral heap model and checks result words in order against it.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_N    = ffha_pkg::HEAP_BYTES_DEF / 4;
    localparam int CYCLE_CAP = 3_000_000;

    typedef struct packed {
        logic [31:0]       addr;
        ffha_pkg::t_status st;
    } t_grant;

    // Behavioral heap and in-order store of expected grants.
    class heap_scoreboard;
        bit          hdr_start[SLOT_N];
        bit          hdr_free[SLOT_N];
        int unsigned hdr_size[SLOT_N];
        int unsigned brk;
        logic [31:0] base;
        int unsigned limit;
        t_grant      pending_grants[$];
        int          errors;

        function void clear();
            for (int i = 0; i < SLOT_N; i++) begin
                hdr_start[i] = 0;
                hdr_free[i] = 0;
                hdr_size[i] = 0;
            end
            brk = 0;
            base = 0;
            limit = 16384;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == ffha_pkg::CFG_HEAP_BASE) base = val;
            else limit = val[14:0];
        endfunction

        function int unsigned next_blk(int unsigned off);
            return off + ffha_pkg::HEADER_BYTES + hdr_size[(off >> 2) % SLOT_N];
        endfunction

        function void merge_free();
            int unsigned off, s, t, nx;
            off = 0;
            while (off < brk) begin
                s = (off >> 2) % SLOT_N;
                nx = next_blk(off);
                if (hdr_free[s] && nx < brk) begin
                    t = (nx >> 2) % SLOT_N;
                    if (hdr_free[t]) begin
                        hdr_size[s] += hdr_size[t] + ffha_pkg::HEADER_BYTES;
                        hdr_start[t] = 0;
                        hdr_free[t] = 0;
                        hdr_size[t] = 0;
                        continue;
                    end
                end
                off = nx;
            end
        endfunction

        function t_grant allocate(int unsigned req);
            t_grant g;
            int unsigned need, off, s, spare, r, lim, fin;
            g.addr = 0;
            g.st = ffha_pkg::ST_FAIL;
            need = (req + 3) & ~32'd3;
            if (need == 0) return g;
            off = 0;
            while (off < brk) begin
                s = (off >> 2) % SLOT_N;
                if (hdr_free[s] && hdr_size[s] >= need) begin
                    spare = hdr_size[s] - need;
                    if (spare >= ffha_pkg::MIN_SPLIT_BYTES) begin
                        r = ((off + ffha_pkg::HEADER_BYTES + need) >> 2) % SLOT_N;
                        hdr_start[r] = 1;
                        hdr_free[r] = 1;
                        hdr_size[r] = spare - ffha_pkg::HEADER_BYTES;
                        hdr_size[s] = need;
                    end
                    hdr_free[s] = 0;
                    g.addr = base + off + ffha_pkg::HEADER_BYTES;
                    g.st = ffha_pkg::ST_OK;
                    return g;
                end
                off = next_blk(off);
            end
            lim = limit < ffha_pkg::HEAP_BYTES_DEF ? limit : ffha_pkg::HEAP_BYTES_DEF;
            fin = brk + ffha_pkg::HEADER_BYTES + need;
            if (fin > lim) return g;
            s = (brk >> 2) % SLOT_N;
            hdr_start[s] = 1;
            hdr_free[s] = 0;
            hdr_size[s] = need;
            g.addr = base + brk + ffha_pkg::HEADER_BYTES;
            g.st = ffha_pkg::ST_OK;
            brk = fin;
            return g;
        endfunction

        function ffha_pkg::t_status release_blk(logic [31:0] a);
            logic [31:0] off, h;
            int unsigned s;
            if (a == 0) return ffha_pkg::ST_OK;
            off = a - base;
            if (off < ffha_pkg::HEADER_BYTES) return ffha_pkg::ST_BAD;
            h = off - ffha_pkg::HEADER_BYTES;
            if (h >= brk || h[1:0] != 0) return ffha_pkg::ST_BAD;
            s = (h >> 2) % SLOT_N;
            if (!hdr_start[s]) return ffha_pkg::ST_BAD;
            if (hdr_free[s]) return ffha_pkg::ST_DOUBLE;
            hdr_free[s] = 1;
            merge_free();
            return ffha_pkg::ST_OK;
        endfunction

        // Note an accepted word and queue the grant it must produce.
        function void note_word(logic cmd, logic [14:0] req, logic [31:0] rel);
            t_grant g;
            if (cmd == ffha_pkg::CMD_ALLOC) begin
                g = allocate(req);
            end else begin
                g.addr = 0;
                g.st = release_blk(rel);
            end
            pending_grants.push_back(g);
        endfunction

        function void check_grant(logic [31:0] addr, logic [1:0] st);
            t_grant g;
            if (pending_grants.size() == 0) begin
                $error("unexpected result word addr=%h status=%0d", addr, st);
                errors++;
                return;
            end
            g = pending_grants.pop_front();
            if (addr !== g.addr) begin
                $error("payload_address expected %h actual %h", g.addr, addr);
                errors++;
            end
            if (st !== g.st) begin
                $error("status expected %0d actual %0d", g.st, st);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic        i_cmd = 0;
    logic [14:0] i_request_bytes = 0;
    logic [31:0] i_release_address = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [31:0] o_payload_address;
    logic [1:0]  o_status;

    heap_scoreboard sb = new();
    logic [31:0] live_addrs[$];
    int          cycles = 0;
    bit          hold_mode = 0;
    int          hold_left = 0;

    always #10 i_clk = ~i_clk;

    first_fit_heap_allocator_core uut (.*);

    // Abort on a runaway run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("first_fit_heap_allocator_core verification failed");
            $finish;
        end
    end

    // Check each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_grant(o_payload_address, o_status);
            if (o_status == ffha_pkg::ST_OK && o_payload_address != 0)
                live_addrs.push_back(o_payload_address);
        end
    end

    // Receiver stall pattern; a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1;
        end else if (hold_mode) begin
            i_out_stall <= 0;
        end else begin
            i_out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic cfg_write(logic idx, logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 0;
    endtask

    // Offer one word, hold it until taken, then predict it.
    task automatic send_word(logic cmd, logic [14:0] req, logic [31:0] rel);
        i_in_valid <= 1;
        i_cmd <= cmd;
        i_request_bytes <= req;
        i_release_address <= rel;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(cmd, req, rel);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
        if (n > 0) begin
            i_in_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending_grants.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Pick a free address: mostly live blocks, sometimes junk.
    function automatic logic [31:0] pick_release();
        int k;
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom();
            2: return sb.base + $urandom_range(0, 600);
            default: begin
                if (live_addrs.size() == 0) return sb.base + 16;
                k = $urandom_range(0, live_addrs.size() - 1);
                pick_release = live_addrs[k];
                if ($urandom_range(0, 4) != 0) live_addrs.delete(k);
            end
        endcase
    endfunction

    task automatic random_words(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0) begin
                if ($urandom_range(0, 1) == 0)
                    send_word(ffha_pkg::CMD_ALLOC, $urandom_range(0, 7) == 0 ?
                              15'($urandom()) : 15'($urandom_range(0, 200)),
                              $urandom());
                else
                    send_word(ffha_pkg::CMD_FREE, 15'($urandom()), pick_release());
                burst--;
                n--;
            end
            idle_gap();
        end
    endtask

    initial begin
        sb.clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, exact and split fits, bad and double frees.
        cfg_write(ffha_pkg::CFG_HEAP_BASE, 32'h0000_1000);
        send_word(ffha_pkg::CMD_ALLOC, 15'd0, 32'd0);
        send_word(ffha_pkg::CMD_ALLOC, 15'd1, 32'hFFFF_FFFF);
        send_word(ffha_pkg::CMD_ALLOC, 15'd100, 32'd0);
        send_word(ffha_pkg::CMD_ALLOC, 15'd8, 32'd0);
        send_word(ffha_pkg::CMD_ALLOC, 15'h7FFF, 32'd0);
        send_word(ffha_pkg::CMD_FREE, 15'h7FFF, 32'd0);
        send_word(ffha_pkg::CMD_FREE, 15'd0, 32'h0000_1024);
        send_word(ffha_pkg::CMD_FREE, 15'd0, 32'h0000_1024);
        send_word(ffha_pkg::CMD_FREE, 15'd0, 32'h0000_0FFF);
        send_word(ffha_pkg::CMD_FREE, 15'd0, 32'hFFFF_FFFF);
        send_word(ffha_pkg::CMD_FREE, 15'd0, 32'h0000_1026);
        send_word(ffha_pkg::CMD_FREE, 15'd0, 32'h0000_1028);
        send_word(ffha_pkg::CMD_ALLOC, 15'd20, 32'd0);
        send_word(ffha_pkg::CMD_ALLOC, 15'd100, 32'd0);
        send_word(ffha_pkg::CMD_FREE, 15'd0, 32'h0000_1010);
        send_word(ffha_pkg::CMD_FREE, 15'd0, 32'h0000_1098);
        send_word(ffha_pkg::CMD_ALLOC, 15'd40, 32'd0);
        send_word(ffha_pkg::CMD_ALLOC, 15'd16384, 32'd0);
        send_word(ffha_pkg::CMD_ALLOC, 15'd16300, 32'd0);
        drain();

        // Tight limit then full limit, with extreme base values.
        cfg_write(ffha_pkg::CFG_HEAP_LIMIT, 32'd0);
        cfg_write(ffha_pkg::CFG_HEAP_BASE, 32'hFFFF_FFF0);
        send_word(ffha_pkg::CMD_ALLOC, 15'd4, 32'd0);
        random_words(40);
        drain();
        cfg_write(ffha_pkg::CFG_HEAP_LIMIT, 32'h7FFF);
        cfg_write(ffha_pkg::CFG_HEAP_BASE, 32'h0000_0000);
        live_addrs.delete();
        random_words(60);
        drain();

        // Long receiver hold-off while words keep coming.
        hold_mode = 1;
        hold_left = 400;
        random_words(30);
        drain();
        hold_mode = 0;

        cfg_write(ffha_pkg::CFG_HEAP_LIMIT, 32'd2000);
        cfg_write(ffha_pkg::CFG_HEAP_BASE, $urandom());
        live_addrs.delete();
        random_words(80);
        drain();
        cfg_write(ffha_pkg::CFG_HEAP_LIMIT, 32'd16384);
        random_words(60);
        drain();

        if (sb.errors == 0 && sb.pending_grants.size() == 0)
            $display("first_fit_heap_allocator_core verification clean");
        else
            $display("first_fit_heap_allocator_core verification failed");
        $finish;
    end
endmodule

/* files.f */
hdl/ffha_pkg.sv
hdl/ffha_ctrl.sv
hdl/ffha_dp.sv
hdl/first_fit_heap_allocator_core.sv
test/tb.sv
